[sv/so3em_pkg.sv]
package so3em_pkg;

  // fixed-point constants
  localparam logic signed [35:0] ONE_Q30      = 36'sh040000000;
  localparam logic signed [35:0] PI_Q30       = 36'sh0C90FDAA2;
  localparam logic signed [35:0] HALF_PI_Q30  = 36'sh06487ED51;
  localparam logic signed [35:0] TWO_PI_Q30   = 36'sh1921FB544;
  localparam logic signed [35:0] GAIN_Q30     = 36'sh026DD3B6A;
  localparam logic [63:0]        TWO_PI_Q40   = 64'h000006487ED5110B;

  localparam int ADDR_MIN_RATE_NORM = 0;

  // arctangent table, truncated Q.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0:  t = 32'h3243F6A8;  5'd1:  t = 32'h1DAC6705;
      5'd2:  t = 32'h0FADBAFC;  5'd3:  t = 32'h07F56EA6;
      5'd4:  t = 32'h03FEAB76;  5'd5:  t = 32'h01FFD55B;
      5'd6:  t = 32'h00FFFAAA;  5'd7:  t = 32'h007FFF55;
      5'd8:  t = 32'h003FFFEA;  5'd9:  t = 32'h001FFFFD;
      5'd10: t = 32'h000FFFFF;  5'd11: t = 32'h0007FFFF;
      5'd12: t = 32'h0003FFFF;  5'd13: t = 32'h0001FFFF;
      5'd14: t = 32'h0000FFFF;  5'd15: t = 32'h00007FFF;
      5'd16: t = 32'h00003FFF;  5'd17: t = 32'h00001FFF;
      5'd18: t = 32'h00000FFF;  5'd19: t = 32'h000007FF;
      5'd20: t = 32'h000003FF;  5'd21: t = 32'h000001FF;
      5'd22: t = 32'h000000FF;  5'd23: t = 32'h0000007F;
      5'd24: t = 32'h0000003F;  5'd25: t = 32'h0000001F;
      5'd26: t = 32'h0000000F;  5'd27: t = 32'h00000008;
      5'd28: t = 32'h00000004;  5'd29: t = 32'h00000002;
      5'd30: t = 32'h00000001;  default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  // clamp to [-1.0, 1.0] in Q2.30
  function automatic logic [31:0] clamp_unit(input logic signed [71:0] v);
    logic [31:0] r;
    if (v > 72'(ONE_Q30)) r = 32'h40000000;
    else if (v < -72'(ONE_Q30)) r = 32'hC0000000;
    else r = v[31:0];
    return r;
  endfunction

  // control tag riding beside the row
  typedef struct packed {
    logic vld;
    logic ident;
    logic flip;
  } tag_t;

endpackage

[sv/so3em_sqrt_cell.sv]
// one restoring square root cell: result bit per cell
module so3em_sqrt_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [5:0]  pos,
  input  logic [63:0] rem_in,
  input  logic [31:0] root_in,
  output logic [63:0] rem_out,
  output logic [31:0] root_out
);
  import so3em_pkg::*;
  logic [65:0] trial;
  logic [65:0] rem_x;

  always_comb begin
    trial = ({34'd0, root_in} << (pos + 6'd1)) | (66'd1 << (2 * pos));
    rem_x = {2'd0, rem_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_x >= trial) begin
        rem_out  <= 64'(rem_x - trial);
        root_out <= root_in | (32'd1 << pos[4:0]);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end
endmodule

[sv/so3em_div_cell.sv]
// one restoring division cell: three quotient bits in parallel lanes
module so3em_div_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [5:0]  pos,
  input  logic [31:0] den,
  input  logic [62:0] rem_in  [3],
  input  logic [31:0] quo_in  [3],
  output logic [62:0] rem_out [3],
  output logic [31:0] quo_out [3]
);
  import so3em_pkg::*;
  logic [94:0] sub [3];

  always_comb begin
    for (int k = 0; k < 3; k++) sub[k] = {63'd0, den} << pos;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if ({32'd0, rem_in[k]} >= sub[k]) begin
          rem_out[k] <= 63'({32'd0, rem_in[k]} - sub[k]);
          quo_out[k] <= quo_in[k] | (32'd1 << pos[4:0]);
        end else begin
          rem_out[k] <= rem_in[k];
          quo_out[k] <= quo_in[k];
        end
      end
    end
  end
endmodule

[sv/so3em_cordic_cell.sv]
// one rotation-mode cordic cell
module so3em_cordic_cell (
  input  logic               clk,
  input  logic               en,
  input  logic [4:0]         step,
  input  logic signed [35:0] x_in,
  input  logic signed [35:0] y_in,
  input  logic signed [35:0] z_in,
  output logic signed [35:0] x_out,
  output logic signed [35:0] y_out,
  output logic signed [35:0] z_out
);
  import so3em_pkg::*;
  logic signed [35:0] dx, dy, at;

  always_comb begin
    dx = y_in >>> step;
    dy = x_in >>> step;
    at = 36'(signed'({1'b0, atan_q30(step)}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[35]) begin
        x_out <= x_in - dx;  y_out <= y_in + dy;  z_out <= z_in - at;
      end else begin
        x_out <= x_in + dx;  y_out <= y_in - dy;  z_out <= z_in + at;
      end
    end
  end
endmodule

[sv/so3_exponential_map_unit.sv]
// Rodrigues rotation unit. Takes one rate vector and time step per beat and
// returns one 3x3 rotation matrix per beat, fully pipelined: a new beat is
// taken every cycle while the output side accepts. After the square-sum
// register that takes the beat, it passes through 32 square-root cells, the
// threshold/angle product register, 32 divider cells with the angle modulo
// riding alongside, the angle fold register, CORDIC_STEPS cordic cells, and
// the sin/cos/K*K and output registers. The whole row advances only when the
// output register is free, so backpressure stalls every cell together.
module so3_exponential_map_unit #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // rate_x, rate_y, rate_z, step_time
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import so3em_pkg::*;

  localparam int SQ_N = 32;
  localparam int DV_N = 32;
  localparam int LAT  = SQ_N + DV_N + CORDIC_STEPS + 4;

  logic [15:0] min_rate_norm;
  logic        en;

  // configuration register
  assign pready = 1'b1;
  assign prdata = {16'd0, min_rate_norm};
  always_ff @(posedge clk) begin
    if (rst) min_rate_norm <= '0;
    else if (psel && penable && pwrite && paddr == 1'(ADDR_MIN_RATE_NORM))
      min_rate_norm <= pwdata[15:0];
  end

  // global advance: row moves when the output slot is empty or drains
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // valid shift line across all cells
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], s_tvalid};
  end

  // stage 0: square sum
  logic signed [31:0] w0 [3];
  logic [31:0] dt0;
  logic [63:0] sq_sum;
  logic signed [63:0] sq_x, sq_y, sq_z;
  always_comb begin
    sq_x = $signed(s_tdata[31:0]) * $signed(s_tdata[31:0]);
    sq_y = $signed(s_tdata[63:32]) * $signed(s_tdata[63:32]);
    sq_z = $signed(s_tdata[95:64]) * $signed(s_tdata[95:64]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      w0[0] <= s_tdata[31:0];
      w0[1] <= s_tdata[63:32];
      w0[2] <= s_tdata[95:64];
      dt0   <= s_tdata[127:96];
      sq_sum <= 64'(sq_x + sq_y + sq_z);
    end
  end

  // square root row, passengers delayed alongside
  logic [63:0] sq_rem  [SQ_N+1];
  logic [31:0] sq_root [SQ_N+1];
  logic signed [31:0] sq_w [SQ_N+1][3];
  logic [31:0] sq_dt [SQ_N+1];
  assign sq_rem[0] = sq_sum;
  assign sq_root[0] = '0;
  assign sq_w[0] = w0;
  assign sq_dt[0] = dt0;
  for (genvar g = 0; g < SQ_N; g++) begin : g_sq
    so3em_sqrt_cell u_cell (
      .clk(clk), .en(en), .pos(6'(SQ_N - 1 - g)),
      .rem_in(sq_rem[g]), .root_in(sq_root[g]),
      .rem_out(sq_rem[g+1]), .root_out(sq_root[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sq_w[g+1]  <= sq_w[g];
        sq_dt[g+1] <= sq_dt[g];
      end
    end
  end

  // threshold, magnitudes and angle product
  logic [31:0] nrm1;
  logic        id1;
  logic        neg1 [3];
  logic [62:0] mag1 [3];
  logic [63:0] prod1;
  always_ff @(posedge clk) begin
    if (en) begin
      nrm1  <= sq_root[SQ_N];
      id1   <= sq_root[SQ_N] <= {16'd0, min_rate_norm};
      prod1 <= 64'(sq_root[SQ_N]) * 64'(sq_dt[SQ_N]);
      for (int k = 0; k < 3; k++) begin
        neg1[k] <= sq_w[SQ_N][k][31];
        mag1[k] <= {1'b0, (sq_w[SQ_N][k][31] ? 32'(-sq_w[SQ_N][k]) :
                    32'(sq_w[SQ_N][k])), 30'd0};
      end
    end
  end

  // divider row; angle product reduced alongside by conditional subtract cells
  logic [62:0] dv_rem [DV_N+1][3];
  logic [31:0] dv_quo [DV_N+1][3];
  logic [63:0] ang    [DV_N+1];
  logic [31:0] dv_den [DV_N+1];
  logic        dv_id  [DV_N+1];
  logic        dv_neg [DV_N+1][3];
  assign dv_rem[0] = mag1;
  assign dv_den[0] = nrm1;
  assign ang[0] = prod1;
  assign dv_id[0] = id1;
  assign dv_neg[0] = neg1;
  for (genvar k = 0; k < 3; k++) begin : g_q0
    assign dv_quo[0][k] = '0;
  end
  for (genvar g = 0; g < DV_N; g++) begin : g_dv
    so3em_div_cell u_cell (
      .clk(clk), .en(en), .pos(6'(DV_N - 1 - g)), .den(dv_den[g]),
      .rem_in(dv_rem[g]), .quo_in(dv_quo[g]),
      .rem_out(dv_rem[g+1]), .quo_out(dv_quo[g+1])
    );
    // modulo 2*pi: product < 2^64 and 2*pi*2^23 shifts cover it bit by bit
    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[g+1] <= dv_den[g];
        dv_id[g+1]  <= dv_id[g];
        dv_neg[g+1] <= dv_neg[g];
        if (g < 24 && {8'd0, ang[g]} >= ({8'd0, TWO_PI_Q40} << (23 - g)))
          ang[g+1] <= 64'({8'd0, ang[g]} - ({8'd0, TWO_PI_Q40} << (23 - g)));
        else
          ang[g+1] <= ang[g];
      end
    end
  end

  // fold to [-pi/2, pi/2]; signed unit axis
  logic signed [35:0] z0;
  logic               flip0, id2;
  logic signed [32:0] u2 [3];
  logic signed [35:0] a_full, a_pi;
  always_comb begin
    a_full = 36'(signed'({1'b0, ang[DV_N][44:10]}));
    a_pi   = (a_full > PI_Q30) ? a_full - TWO_PI_Q30 : a_full;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      id2 <= dv_id[DV_N];
      if (a_pi > HALF_PI_Q30) begin
        z0 <= a_pi - PI_Q30;  flip0 <= 1'b1;
      end else if (a_pi < -HALF_PI_Q30) begin
        z0 <= a_pi + PI_Q30;  flip0 <= 1'b1;
      end else begin
        z0 <= a_pi;  flip0 <= 1'b0;
      end
      for (int k = 0; k < 3; k++)
        u2[k] <= dv_neg[DV_N][k] ? -33'(dv_quo[DV_N][k]) : 33'(dv_quo[DV_N][k]);
    end
  end

  // cordic row
  logic signed [35:0] cx [CORDIC_STEPS+1];
  logic signed [35:0] cy [CORDIC_STEPS+1];
  logic signed [35:0] cz [CORDIC_STEPS+1];
  tag_t               ct [CORDIC_STEPS+1];
  logic signed [32:0] cu [CORDIC_STEPS+1][3];
  assign cx[0] = GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = z0;
  assign ct[0] = '{vld: 1'b1, ident: id2, flip: flip0};
  assign cu[0] = u2;
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cd
    so3em_cordic_cell u_cell (
      .clk(clk), .en(en), .step(5'(g)),
      .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
      .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        ct[g+1] <= ct[g];
        cu[g+1] <= cu[g];
      end
    end
  end

  // sin, cos and K*K
  logic signed [35:0] sn3, c13;
  logic [31:0] cs_c;
  logic signed [32:0] u3 [3];
  logic signed [35:0] kk3 [3][3];
  logic id3;
  logic signed [32:0] uu [3];
  always_comb begin
    uu = cu[CORDIC_STEPS];
    cs_c = clamp_unit(72'(ct[CORDIC_STEPS].flip ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS]));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      id3 <= ct[CORDIC_STEPS].ident;
      sn3 <= 36'(signed'(clamp_unit(72'(ct[CORDIC_STEPS].flip ?
                 -cy[CORDIC_STEPS] : cy[CORDIC_STEPS]))));
      c13 <= ONE_Q30 - 36'(signed'(cs_c));
      u3  <= uu;
      // K*K = u u^T - |u|^2 I
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          kk3[i][j] <= 36'((72'(uu[i]) * 72'(uu[j]) -
                       ((i == j) ? (72'(uu[0]) * 72'(uu[0]) + 72'(uu[1]) * 72'(uu[1]) +
                        72'(uu[2]) * 72'(uu[2])) : 72'sd0) + 72'sd536870912) >>> 30);
    end
  end

  // assemble matrix into the output register
  logic signed [35:0] kel [3][3];
  logic [31:0] mm [3][3];
  always_comb begin
    kel[0][0] = '0;          kel[0][1] = -36'(u3[2]); kel[0][2] = 36'(u3[1]);
    kel[1][0] = 36'(u3[2]);  kel[1][1] = '0;          kel[1][2] = -36'(u3[0]);
    kel[2][0] = -36'(u3[1]); kel[2][1] = 36'(u3[0]);  kel[2][2] = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        mm[i][j] = id3 ? ((i == j) ? 32'h40000000 : 32'h0) :
          clamp_unit(((72'(sn3) * 72'(kel[i][j]) + 72'(c13) * 72'(kk3[i][j]) +
                      72'sd536870912) >>> 30) + ((i == j) ? 72'(ONE_Q30) : 72'sd0));
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vld[LAT-1];
  end
  always_ff @(posedge clk) begin
    if (en)
      m_tdata <= {mm[2][2], mm[2][1], mm[2][0], mm[1][2], mm[1][1], mm[1][0],
                  mm[0][2], mm[0][1], mm[0][0]};
  end

  // output holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed under stall");
  // no beat taken while stalled
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken under stall");
  // a beat leaving the row lands in the output register
  a_land: assert property (@(posedge clk) disable iff (rst)
    en && vld[LAT-1] |=> m_tvalid)
    else $error("beat lost");
endmodule

[tb/so3_exponential_map_unit_test.sv]
`timescale 1ns / 1ps

module so3_exponential_map_unit_test;
  import so3em_pkg::*;

  localparam int CORDIC_STEPS = 24;
  localparam int QUIET_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [31:0] STEP_ONE = 32'h01000000;

  // expected rotation matrices and the bit-exact predictor
  class rotation_scoreboard;
    logic [287:0] pending_matrices[$];
    logic [15:0] min_norm;
    int mismatches;
    int matrices_seen;

    function new();
      min_norm = '0;
      mismatches = 0;
      matrices_seen = 0;
    endfunction

    function logic [287:0] rodrigues(logic [127:0] beat);
      longint w[3], u[3], k[3][3], kk[3][3];
      longint acc, sn, cs, c1, v, x, y, z, dx, dy, a, mag;
      longint unsigned sum, norm, rem, res, bitv, r, dt;
      bit flip;
      logic [287:0] mat;
      int i, j, t;
      sum = 0;
      for (i = 0; i < 3; i++) begin
        w[i] = longint'($signed(beat[32*i +: 32]));
        sum += longint'(w[i] * w[i]);
      end
      // bitwise integer square root
      rem = sum;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      norm = res;
      mat = '0;
      if (norm <= longint'(min_norm)) begin
        for (i = 0; i < 3; i++) mat[32*(4*i) +: 32] = 32'h40000000;
        return mat;
      end
      // unit axis, truncated toward zero
      for (i = 0; i < 3; i++) begin
        mag = (w[i] < 0) ? -(w[i] <<< 30) : (w[i] <<< 30);
        u[i] = longint'(longint'(unsigned'(mag)) / norm);
        if (w[i] < 0) u[i] = -u[i];
      end
      k[0][0] = 0;     k[0][1] = -u[2]; k[0][2] = u[1];
      k[1][0] = u[2];  k[1][1] = 0;     k[1][2] = -u[0];
      k[2][0] = -u[1]; k[2][1] = u[0];  k[2][2] = 0;
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3; j++) begin
          acc = 0;
          for (t = 0; t < 3; t++) acc += k[i][t] * k[t][j];
          kk[i][j] = (acc + (64'sd1 <<< 29)) >>> 30;
        end
      // angle reduction into [-pi/2, pi/2]
      dt = beat[127:96];
      r = (norm * dt) % TWO_PI_Q40;
      a = longint'(r >> 10);
      flip = 0;
      if (a > longint'(PI_Q30)) a -= longint'(TWO_PI_Q30);
      if (a > longint'(HALF_PI_Q30)) begin
        a -= longint'(PI_Q30);
        flip = 1;
      end else if (a < -longint'(HALF_PI_Q30)) begin
        a += longint'(PI_Q30);
        flip = 1;
      end
      // rotation-mode cordic
      x = longint'(GAIN_Q30);
      y = 0;
      z = a;
      for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= longint'(atan_q30(5'(i)));
        end else begin
          x += dx;
          y -= dy;
          z += longint'(atan_q30(5'(i)));
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      cs = x;
      if (cs > (64'sd1 <<< 30)) cs = 64'sd1 <<< 30;
      if (cs < -(64'sd1 <<< 30)) cs = -(64'sd1 <<< 30);
      sn = y;
      if (sn > (64'sd1 <<< 30)) sn = 64'sd1 <<< 30;
      if (sn < -(64'sd1 <<< 30)) sn = -(64'sd1 <<< 30);
      c1 = (64'sd1 <<< 30) - cs;
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3; j++) begin
          v = (sn * k[i][j] + c1 * kk[i][j] + (64'sd1 <<< 29)) >>> 30;
          if (i == j) v += 64'sd1 <<< 30;
          if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
          if (v < -(64'sd1 <<< 30)) v = -(64'sd1 <<< 30);
          mat[32*(3*i+j) +: 32] = v[31:0];
        end
      return mat;
    endfunction

    function void note_rate(logic [127:0] beat);
      pending_matrices.insert(pending_matrices.size(), rodrigues(beat));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h (matrix %0d)", what, got, want, matrices_seen);
      mismatches++;
    endtask

    task check_matrix(logic [287:0] got);
      logic [287:0] want;
      int e;
      if (pending_matrices.size() == 0) begin
        report_mismatch("unexpected matrix", got[31:0], 32'h0);
      end else begin
        want = pending_matrices.pop_front();
        for (e = 0; e < 9; e++)
          if (got[32*e +: 32] !== want[32*e +: 32])
            report_mismatch($sformatf("m%0d%0d", e / 3, e % 3), got[32*e +: 32],
                            want[32*e +: 32]);
      end
      matrices_seen++;
    endtask
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [127:0] s_tdata;  // rate_x, rate_y, rate_z, step_time
  logic [287:0] m_tdata;  // m00 m01 m02 m10 m11 m12 m20 m21 m22
  logic psel, penable, pwrite, pready;
  logic [0:0] paddr;
  logic [31:0] pwdata, prdata;

  rotation_scoreboard sb;
  bit idling_on;
  int stall_left;
  int quiet_cycles;
  int rates_sent;

  so3_exponential_map_unit #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (.*);

  always #6 clk = ~clk;

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(1, 13) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // output monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_matrix(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("watchdog expired with %0d matrices outstanding",
                   sb.pending_matrices.size());
          $display("so3_exponential_map_unit_test: FAIL");
          $finish;
        end
      end
    end
  end

  task apb_write(logic [0:0] addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 1'(ADDR_MIN_RATE_NORM)) sb.min_norm = value[15:0];
  endtask

  // one input beat, sometimes with a random gap after it
  task send_rate(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz, logic [31:0] st);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {st, rz, ry, rx};
    do @(posedge clk); while (!s_tready);
    sb.note_rate({st, rz, ry, rx});
    rates_sent++;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending_matrices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [31:0] random_rate();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 20000) - 10000;
      2: v = $urandom_range(0, 32'h40000) - 32'h20000;
      3: v = $urandom_range(0, 32'h4000000) - 32'h2000000;
      default: v = $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                        : 32'h80000000 + $urandom_range(0, 255);
    endcase
    return v;
  endfunction

  function logic [31:0] random_step();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = STEP_ONE;
      2: v = $urandom_range(0, 32'h00100000);
      3: v = $urandom_range(0, 32'h04000000);
      default: v = $urandom_range(0, 1) ? 32'h0 : 32'hFFFFFFFF;
    endcase
    return v;
  endfunction

  task random_phase(int count);
    int n;
    for (n = 0; n < count; n++)
      send_rate(random_rate(), random_rate(), random_rate(), random_step());
  endtask

  initial begin
    clk = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    sb = new();
    idling_on = 1;
    rates_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    apb_write(1'(ADDR_MIN_RATE_NORM), 32'h0);

    // directed: zero rate, field extremes, step extremes, axes
    send_rate(32'h0, 32'h0, 32'h0, STEP_ONE);
    send_rate(32'h1, 32'h0, 32'h0, STEP_ONE);
    send_rate(32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    send_rate(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_rate(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, STEP_ONE);
    send_rate(32'h00010000, 32'h0, 32'h0, 32'h0);
    send_rate(32'h0, 32'h00010000, 32'h0, STEP_ONE);
    send_rate(32'h0, 32'h0, 32'hFFFF0000, STEP_ONE);
    send_rate(32'h0003243F, 32'h0, 32'h0, STEP_ONE);
    send_rate(32'hFFFCDBC1, 32'h0, 32'h0, STEP_ONE);
    send_rate(32'h0001921F, 32'h0001921F, 32'h0, STEP_ONE);
    send_rate(32'h00064880, 32'h0, 32'h0, 32'h00800000);
    send_rate(32'h12345678, 32'hEDCBA987, 32'h0F0F0F0F, 32'h00000001);
    send_rate(32'h00010000, 32'h00020000, 32'h00030000, 32'h80000000);
    drain();

    // threshold at its top: just at and just above
    apb_write(1'(ADDR_MIN_RATE_NORM), 32'hFFFF_FFFF);
    send_rate(32'h0000FFFF, 32'h0, 32'h0, STEP_ONE);
    send_rate(32'h00010000, 32'h0, 32'h0, STEP_ONE);
    send_rate(32'h0, 32'hFFFF0001, 32'h0, STEP_ONE);
    send_rate(32'h0, 32'h0, 32'hFFFF0000, STEP_ONE);
    random_phase(350);
    drain();

    apb_write(1'(ADDR_MIN_RATE_NORM), $urandom_range(1, 65534));
    random_phase(450);
    drain();

    apb_write(1'(ADDR_MIN_RATE_NORM), 32'h0);
    random_phase(500);

    // closing stretch with no idling on either side
    idling_on = 0;
    random_phase(400);
    drain();

    $display("sent %0d rate vectors, checked %0d matrices", rates_sent, sb.matrices_seen);
    $display("threshold settings: zero, top, random; idle bursts on both sides, then none");
    if (sb.mismatches == 0)
      $display("so3_exponential_map_unit_test: PASS");
    else
      $display("so3_exponential_map_unit_test: FAIL");
    $finish;
  end

endmodule

[files.f]
sv/so3em_pkg.sv
sv/so3em_sqrt_cell.sv
sv/so3em_div_cell.sv
sv/so3em_cordic_cell.sv
sv/so3_exponential_map_unit.sv
tb/so3_exponential_map_unit_test.sv
